FILE: rtl/core/bleadv_pkg.sv
// Shared types and constants for the advertising data part splitter.
// No dependencies; used by the input stage, the parser, the top level and the bench.
`default_nettype none

package bleadv_pkg;

    // a part needs at least a length, a type and room for payload
    localparam logic [7:0] MIN_PART_BYTES = 8'd3;

    // one accepted input item
    typedef struct packed {
        logic [7:0] byte_value;
        logic       first_of_report;
        logic [7:0] report_length;
    } t_item;

    // one result item
    typedef struct packed {
        logic [7:0] part_type;
        logic [7:0] value_byte;
        logic       value_valid;
        logic [7:0] byte_index;
        logic       part_end;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/bleadv_in_stage.sv
// Input register of the part splitter: holds one accepted item until the
// parser stage takes it. Depends on bleadv_pkg.
`default_nettype none

module bleadv_in_stage (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire bleadv_pkg::t_item   i_item,
    input  wire                      i_advance,
    output logic                     o_valid,
    output bleadv_pkg::t_item        o_item
);

    logic              r_valid;
    logic              n_valid;
    bleadv_pkg::t_item r_item;

    // free when empty or when the held item moves on this cycle
    assign o_in_ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (o_in_ready) begin
            n_valid = i_in_valid;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

FILE: rtl/core/bleadv_parser.sv
// Parser state of the part splitter: updates the length-type-value state
// for one item per advance and forms its result. Depends on bleadv_pkg.
`default_nettype none

module bleadv_parser (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_advance,
    input  wire bleadv_pkg::t_item   i_item,
    output logic                     o_has_result,
    output bleadv_pkg::t_result      o_result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEN,
        PH_TYPE,
        PH_PAYLOAD
    } t_phase;

    t_phase     r_phase,     n_phase;
    logic [7:0] r_bytes_rem, n_bytes_rem;
    logic [7:0] r_pay_left,  n_pay_left;
    logic [7:0] r_cur_type,  n_cur_type;
    logic [7:0] r_pay_pos,   n_pay_pos;

    // state as seen after a report start
    t_phase     s_phase;
    logic [7:0] s_bytes_rem;
    logic [7:0] s_pay_left;
    logic [7:0] s_cur_type;
    logic [7:0] s_pay_pos;

    logic [7:0] after;
    logic [7:0] len_m1;
    logic [7:0] count;

    always_comb begin
        // a first byte restarts the parser
        s_phase     = r_phase;
        s_bytes_rem = r_bytes_rem;
        s_pay_left  = r_pay_left;
        s_cur_type  = r_cur_type;
        s_pay_pos   = r_pay_pos;
        if (i_item.first_of_report) begin
            s_phase     = PH_LEN;
            s_bytes_rem = i_item.report_length;
            s_pay_left  = 8'd0;
            s_cur_type  = 8'd0;
            s_pay_pos   = 8'd0;
        end

        // payload count of a new part, clipped to the bytes left
        after  = s_bytes_rem - 8'd1;
        len_m1 = s_pay_left - 8'd1;
        if (s_pay_left == 8'd0 || len_m1 > after) begin
            count = after;
        end else begin
            count = len_m1;
        end

        n_phase      = s_phase;
        n_bytes_rem  = s_bytes_rem;
        n_pay_left   = s_pay_left;
        n_cur_type   = s_cur_type;
        n_pay_pos    = s_pay_pos;
        o_has_result = 1'b0;
        o_result     = '0;

        unique case (s_phase)
            PH_IDLE: begin
            end
            PH_LEN: begin
                if (s_bytes_rem < bleadv_pkg::MIN_PART_BYTES) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_pay_left  = i_item.byte_value;
                    n_bytes_rem = s_bytes_rem - 8'd1;
                    n_phase     = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_cur_type  = i_item.byte_value;
                n_bytes_rem = after;
                n_pay_pos   = 8'd0;
                if (count == 8'd0) begin
                    // empty part marker
                    n_pay_left           = 8'd0;
                    n_phase              = PH_LEN;
                    o_has_result         = 1'b1;
                    o_result.part_type   = i_item.byte_value;
                    o_result.part_end    = 1'b1;
                end else begin
                    n_pay_left = count;
                    n_phase    = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                o_has_result         = 1'b1;
                o_result.part_type   = s_cur_type;
                o_result.value_byte  = i_item.byte_value;
                o_result.value_valid = 1'b1;
                o_result.byte_index  = s_pay_pos;
                o_result.part_end    = (s_pay_left <= 8'd1);
                n_pay_pos            = s_pay_pos + 8'd1;
                n_pay_left           = s_pay_left - 8'd1;
                n_bytes_rem          = s_bytes_rem - 8'd1;
                if (s_pay_left <= 8'd1) begin
                    n_phase = PH_LEN;
                end
            end
            default: begin
            end
        endcase
    end

    // parser state, updated once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bytes_rem <= 8'd0;
            r_pay_left  <= 8'd0;
            r_cur_type  <= 8'd0;
            r_pay_pos   <= 8'd0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_bytes_rem <= n_bytes_rem;
            r_pay_left  <= n_pay_left;
            r_cur_type  <= n_cur_type;
            r_pay_pos   <= n_pay_pos;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ble_adv_data_part_splitter_core.sv
// Top level of the advertising data part splitter: input register, parser
// and result register. Depends on bleadv_pkg, bleadv_in_stage, bleadv_parser.
//
// Takes one advertising data byte per item and splits the report into
// length-type-value parts, giving zero or one result per byte. One item is
// accepted every clock cycle while results are taken; each byte is held in
// the input register, and the parser update for it is loaded into the
// result register when that register is free or being emptied, where the
// result is offered until taken. The parser state updates once per byte,
// which sets the rate of one byte per clock while results are taken. The
// input stays ready while a finished result waits, as long as the result
// register frees up when the parser stage needs it.
`default_nettype none

module ble_adv_data_part_splitter_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_byte_value,
    input  wire         i_first_of_report,
    input  wire  [7:0]  i_report_length,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_part_type,
    output logic [7:0]  o_value_byte,
    output logic        o_value_valid,
    output logic [7:0]  o_byte_index,
    output logic        o_part_end
);

    bleadv_pkg::t_item   in_item;
    bleadv_pkg::t_item   stage_item;
    bleadv_pkg::t_result parse_result;
    bleadv_pkg::t_result r_out;
    logic                stage_valid;
    logic                advance;
    logic                has_result;
    logic                r_out_valid;
    logic                n_out_valid;

    assign in_item.byte_value      = i_byte_value;
    assign in_item.first_of_report = i_first_of_report;
    assign in_item.report_length   = i_report_length;

    // parser moves when the result register is free or being emptied
    assign advance = stage_valid && (!r_out_valid || i_out_ready);

    bleadv_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_item     (in_item),
        .i_advance  (advance),
        .o_valid    (stage_valid),
        .o_item     (stage_item)
    );

    bleadv_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_item       (stage_item),
        .o_has_result (has_result),
        .o_result     (parse_result)
    );

    // result valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = has_result;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_out <= parse_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_part_type   = r_out.part_type;
    assign o_value_byte  = r_out.value_byte;
    assign o_value_valid = r_out.value_valid;
    assign o_byte_index  = r_out.byte_index;
    assign o_part_end    = r_out.part_end;

endmodule

`default_nettype wire

FILE: rtl/core/bleadv_checker.sv
// Port checker for the part splitter top level, bound to it below.
// Depends only on the ports of ble_adv_data_part_splitter_core.
`default_nettype none

module bleadv_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire [7:0]  o_value_byte,
    input wire        o_value_valid,
    input wire [7:0]  o_byte_index,
    input wire        o_part_end
);

    // a stalled result item stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    // an empty part marker is a bare, closing result
    a_empty_part: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_value_valid |->
            o_part_end && o_value_byte == 8'd0 && o_byte_index == 8'd0)
        else $error("malformed empty part marker");

    // a part never holds more payload than a full report allows
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_byte_index <= 8'd252)
        else $error("payload index out of range");

    // reset leaves no result offered
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

endmodule

bind ble_adv_data_part_splitter_core bleadv_checker u_bleadv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_value_byte  (o_value_byte),
    .o_value_valid (o_value_valid),
    .o_byte_index  (o_byte_index),
    .o_part_end    (o_part_end)
);

`default_nettype wire

FILE: bench/ble_adv_data_part_splitter_core_tb.sv
// Self-checking bench for ble_adv_data_part_splitter_core: random and directed reports,
// results checked against a behavioral parser kept inside the bench.
// Depends on bleadv_pkg and the core RTL only.
`default_nettype none

module ble_adv_data_part_splitter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    // phases of the behavioral parser
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_LENGTH  = 2'd1,
        ST_TYPE    = 2'd2,
        ST_PAYLOAD = 2'd3
    } parse_phase_e;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] byte_value = 8'd0;
    logic       first_of_report = 1'b0;
    logic [7:0] report_length = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] part_type;
    logic [7:0] value_byte;
    logic       value_valid;
    logic [7:0] byte_index;
    logic       part_end;

    int send_idle_pct = 29;
    int recv_idle_pct = 83;
    int hold_cycles = 0;
    int idle_count = 0;
    int fail_count = 0;
    int report_items = 0;

    // behavioral parser state and the results it still owes
    parse_phase_e        prs_phase = ST_IDLE;
    logic [7:0]          prs_remaining = 8'd0;
    logic [7:0]          prs_payload_left = 8'd0;
    logic [7:0]          prs_type = 8'd0;
    logic [7:0]          prs_index = 8'd0;
    bleadv_pkg::t_result pending_parts[$];
    bleadv_pkg::t_result want;

    ble_adv_data_part_splitter_core dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_byte_value      (byte_value),
        .i_first_of_report (first_of_report),
        .i_report_length   (report_length),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_part_type       (part_type),
        .o_value_byte      (value_byte),
        .o_value_valid     (value_valid),
        .o_byte_index      (byte_index),
        .o_part_end        (part_end)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // queue one expected result
    task automatic expect_part(input logic [7:0] value, input logic valid,
                               input logic [7:0] index, input logic last);
        bleadv_pkg::t_result r;
        r.part_type   = prs_type;
        r.value_byte  = value;
        r.value_valid = valid;
        r.byte_index  = index;
        r.part_end    = last;
        pending_parts.push_back(r);
    endtask

    // advance the behavioral parser by one accepted byte
    task automatic parse_byte(input bleadv_pkg::t_item it);
        logic [7:0] after;
        logic [7:0] count;
        logic [7:0] len_less_one;
        logic       last;
        if (it.first_of_report) begin
            prs_phase        = ST_LENGTH;
            prs_remaining    = it.report_length;
            prs_payload_left = 8'd0;
            prs_type         = 8'd0;
            prs_index        = 8'd0;
        end
        case (prs_phase)
            ST_LENGTH: begin
                if (prs_remaining < bleadv_pkg::MIN_PART_BYTES) begin
                    prs_phase = ST_IDLE;
                end else begin
                    prs_payload_left = it.byte_value;
                    prs_remaining    = prs_remaining - 8'd1;
                    prs_phase        = ST_TYPE;
                end
            end
            ST_TYPE: begin
                prs_type      = it.byte_value;
                after         = prs_remaining - 8'd1;
                prs_remaining = after;
                len_less_one  = prs_payload_left - 8'd1;
                // zero or overlong length takes what is left of the report
                if (prs_payload_left == 8'd0 || len_less_one > after)
                    count = after;
                else
                    count = len_less_one;
                prs_index = 8'd0;
                if (count == 8'd0) begin
                    prs_payload_left = 8'd0;
                    prs_phase        = ST_LENGTH;
                    expect_part(8'd0, 1'b0, 8'd0, 1'b1);
                end else begin
                    prs_payload_left = count;
                    prs_phase        = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD: begin
                last = (prs_payload_left <= 8'd1);
                expect_part(it.byte_value, 1'b1, prs_index, last);
                prs_index        = prs_index + 8'd1;
                prs_payload_left = prs_payload_left - 8'd1;
                prs_remaining    = prs_remaining - 8'd1;
                if (last)
                    prs_phase = ST_LENGTH;
            end
            default: ;
        endcase
    endtask

    // offer one item, optionally after a gap, and return on the accepting edge
    task automatic send_byte(input logic [7:0] b, input logic first, input logic [7:0] rlen);
        bleadv_pkg::t_item it;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid        <= 1'b1;
        byte_value      <= b;
        first_of_report <= first;
        report_length   <= rlen;
        do @(posedge clk); while (!in_ready);
        it.byte_value      = b;
        it.first_of_report = first;
        it.report_length   = rlen;
        parse_byte(it);
    endtask

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        $display("mismatch %s: expected %0d got %0d at %0t", what, exp_val, got_val, $realtime);
        fail_count++;
    endtask

    // result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_parts.size() == 0) begin
                report_mismatch("unexpected result, type", 0, int'(part_type));
            end else begin
                want = pending_parts.pop_front();
                if (part_type !== want.part_type)
                    report_mismatch("part_type", int'(want.part_type), int'(part_type));
                if (value_byte !== want.value_byte)
                    report_mismatch("value_byte", int'(want.value_byte), int'(value_byte));
                if (value_valid !== want.value_valid)
                    report_mismatch("value_valid", int'(want.value_valid),
                                    int'(value_valid));
                if (byte_index !== want.byte_index)
                    report_mismatch("byte_index", int'(want.byte_index), int'(byte_index));
                if (part_end !== want.part_end)
                    report_mismatch("part_end", int'(want.part_end), int'(part_end));
            end
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            out_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    // one report of rlen bytes split into random parts; only send_n bytes go out
    task automatic send_report(input int rlen, input int send_n);
        logic [7:0] content[$];
        int left;
        int len_byte;
        int n;
        int k;
        int cap;
        left = rlen;
        while (left > 0) begin
            if (left < 3) begin
                repeat (left) content.push_back(8'($urandom_range(255)));
                left = 0;
            end else begin
                k = $urandom_range(99);
                if (k < 8) begin
                    len_byte = 0;
                end else if (k < 16) begin
                    len_byte = $urandom_range(255, left);
                end else if (k < 26) begin
                    len_byte = 1;
                end else begin
                    cap = (left - 1 < 12 || $urandom_range(9) == 0) ? left - 1 : 12;
                    len_byte = $urandom_range(cap, 2);
                end
                n = (len_byte == 0 || len_byte - 1 > left - 2) ? left - 2 : len_byte - 1;
                content.push_back(8'(len_byte));
                content.push_back(8'($urandom_range(255)));
                repeat (n) content.push_back(8'($urandom_range(255)));
                left -= n + 2;
            end
        end
        for (int i = 0; i < send_n && i < content.size(); i++) begin
            send_byte(content[i], i == 0, (i == 0) ? 8'(rlen) : 8'($urandom_range(255)));
            report_items++;
        end
    endtask

    // report lengths below three leave the parser idle
    task automatic test_short_reports();
        send_byte(8'h00, 1'b1, 8'd0);
        send_byte(8'hFF, 1'b1, 8'd1);
        send_byte(8'h02, 1'b1, 8'd2);
        send_byte(8'hAB, 1'b0, 8'hFF);
    endtask

    // normal part, empty part, overlong length, then a byte past the report
    task automatic test_part_kinds();
        send_byte(8'h03, 1'b1, 8'd9);
        send_byte(8'hFF, 1'b0, 8'h00);
        send_byte(8'h00, 1'b0, 8'hFF);
        send_byte(8'hFF, 1'b0, 8'h00);
        send_byte(8'h01, 1'b0, 8'h00);
        send_byte(8'h00, 1'b0, 8'h00);
        send_byte(8'h05, 1'b0, 8'h00);
        send_byte(8'hAA, 1'b0, 8'h00);
        send_byte(8'h55, 1'b0, 8'h00);
        send_byte(8'h7E, 1'b0, 8'h00);
    endtask

    // zero length byte takes the rest of the report
    task automatic test_zero_length();
        send_byte(8'h00, 1'b1, 8'd4);
        send_byte(8'h07, 1'b0, 8'h00);
        send_byte(8'h11, 1'b0, 8'h00);
        send_byte(8'h22, 1'b0, 8'h00);
    endtask

    // two bytes left at a part boundary are ignored
    task automatic test_short_tail();
        send_byte(8'h02, 1'b1, 8'd5);
        send_byte(8'h09, 1'b0, 8'h00);
        send_byte(8'h33, 1'b0, 8'h00);
        send_byte(8'h44, 1'b0, 8'h00);
        send_byte(8'h55, 1'b0, 8'h00);
    endtask

    // mostly well-formed reports, some cut short by the next one, some noise
    task automatic test_random_traffic(input int target);
        int start;
        int rlen;
        int k;
        start = report_items;
        while (report_items - start < target) begin
            k = $urandom_range(99);
            if (k < 6)
                rlen = $urandom_range(255, 200);
            else
                rlen = $urandom_range(24, 3);
            k = $urandom_range(99);
            if (k < 75)
                send_report(rlen, rlen);
            else if (k < 87)
                send_report(rlen, $urandom_range(rlen - 1, 1));
            else
                repeat ($urandom_range(3, 1))
                    send_byte(8'($urandom_range(255)), $urandom_range(99) < 40,
                              8'($urandom_range(255)));
        end
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        in_valid <= 1'b0;
        @(negedge clk);
        hold_cycles = 400;
        @(posedge clk);
        send_report(60, 60);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_reports();
        test_part_kinds();
        test_zero_length();
        test_short_tail();
        test_random_traffic(210);

        send_idle_pct = 83;
        recv_idle_pct = 29;
        test_random_traffic(210);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(210);
        test_backpressure();
        in_valid <= 1'b0;

        // drain, then allow for the two stages of the pipeline
        wait (pending_parts.size() == 0);
        repeat (10) @(posedge clk);
        if (pending_parts.size() != 0)
            report_mismatch("results left over", 0, pending_parts.size());
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/bleadv_pkg.sv
rtl/core/bleadv_in_stage.sv
rtl/core/bleadv_parser.sv
rtl/core/ble_adv_data_part_splitter_core.sv
rtl/core/bleadv_checker.sv
bench/ble_adv_data_part_splitter_core_tb.sv
